FILE: src/ppsu_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`timescale 1ns / 1ps

package ppsu_pkg;

  // Fixed widths of the item fields
  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int ORDER_W = 16;
  localparam int INPR_W  = 8;
  localparam int OUT_W   = 16;

  // Operation carried along the cell chain
  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_SCAN,
    OP_EXEC
  } ppsu_op_t;

  // Control word that travels from cell to cell
  typedef struct packed {
    logic     valid;
    ppsu_op_t op;
    logic     hit;
  } ppsu_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_SCAN,
    ST_EXEC,
    ST_CALC
  } ppsu_state_t;

endpackage

FILE: src/ppsu_cell.sv
// One task slot of the scheduler chain: slot storage plus one registered hop of the chain bus.
`timescale 1ns / 1ps

module ppsu_cell
  import ppsu_pkg::*;
#(
  parameter int SLOT_BITS = 3,
  parameter int PRIO_BITS = 8,
  parameter int TIME_BITS = 16,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 run_valid_i,
  input  logic [SLOT_BITS-1:0] run_slot_i,
  input  ppsu_ctrl_t           ctrl_i,
  input  logic [SLOT_BITS-1:0] slot_i,
  input  logic [PRIO_BITS-1:0] prio_i,
  input  logic [ORDER_W-1:0]   order_i,
  input  logic [ID_W-1:0]      id_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [TIME_BITS-1:0] time_i,
  output ppsu_ctrl_t           ctrl_o,
  output logic [SLOT_BITS-1:0] slot_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic [ORDER_W-1:0]   order_o,
  output logic [ID_W-1:0]      id_o,
  output logic [BURST_W-1:0]   burst_o,
  output logic [TIME_BITS-1:0] time_o
);

  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(CELL_IDX);

  // Slot storage
  logic                 vld_r,   vld_nxt;
  logic [ID_W-1:0]      sid_r,   sid_nxt;
  logic [PRIO_BITS-1:0] sprio_r, sprio_nxt;
  logic [BURST_W-1:0]   rem_r,   rem_nxt;
  logic [BURST_W-1:0]   sburst_r, sburst_nxt;
  logic [TIME_BITS-1:0] arr_r,   arr_nxt;
  logic [ORDER_W-1:0]   sord_r,  sord_nxt;

  // Chain hop registers
  ppsu_ctrl_t           bctrl_r,  bctrl_nxt;
  logic [SLOT_BITS-1:0] bslot_r,  bslot_nxt;
  logic [PRIO_BITS-1:0] bprio_r,  bprio_nxt;
  logic [ORDER_W-1:0]   bord_r,   bord_nxt;
  logic [ID_W-1:0]      bid_r,    bid_nxt;
  logic [BURST_W-1:0]   bburst_r, bburst_nxt;
  logic [TIME_BITS-1:0] btime_r,  btime_nxt;

  logic mine;
  logic ready;
  logic wins;

  assign mine  = (slot_i == MY_SLOT);
  assign ready = vld_r && !(run_valid_i && (run_slot_i == MY_SLOT));
  assign wins  = !ctrl_i.hit || (sprio_r < prio_i) ||
                 ((sprio_r == prio_i) && (sord_r < order_i));

  always_comb begin
    vld_nxt    = vld_r;
    sid_nxt    = sid_r;
    sprio_nxt  = sprio_r;
    rem_nxt    = rem_r;
    sburst_nxt = sburst_r;
    arr_nxt    = arr_r;
    sord_nxt   = sord_r;
    bctrl_nxt  = ctrl_i;
    bslot_nxt  = slot_i;
    bprio_nxt  = prio_i;
    bord_nxt   = order_i;
    bid_nxt    = id_i;
    bburst_nxt = burst_i;
    btime_nxt  = time_i;
    if (ctrl_i.valid) begin
      case (ctrl_i.op)
        OP_ARRIVE: begin
          // take the task if no earlier cell did and this slot is free
          if (!ctrl_i.hit && !vld_r) begin
            vld_nxt       = 1'b1;
            sid_nxt       = id_i;
            sprio_nxt     = prio_i;
            rem_nxt       = burst_i;
            sburst_nxt    = burst_i;
            arr_nxt       = time_i;
            sord_nxt      = order_i;
            bctrl_nxt.hit = 1'b1;
          end
        end
        OP_SCAN: begin
          // replace the best-so-far only on a strict win
          if (ready && wins) begin
            bctrl_nxt.hit = 1'b1;
            bslot_nxt     = MY_SLOT;
            bprio_nxt     = sprio_r;
            bord_nxt      = sord_r;
          end
        end
        OP_EXEC: begin
          if (mine) begin
            bid_nxt    = sid_r;
            bburst_nxt = sburst_r;
            btime_nxt  = arr_r;
            if (rem_r <= BURST_W'(1)) begin
              rem_nxt       = '0;
              vld_nxt       = 1'b0;
              bctrl_nxt.hit = 1'b1;
            end else begin
              rem_nxt = rem_r - BURST_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= 1'b0;
      bctrl_r.valid <= 1'b0;
      bctrl_r.op    <= OP_ARRIVE;
      bctrl_r.hit   <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      bctrl_r <= bctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sid_r    <= sid_nxt;
    sprio_r  <= sprio_nxt;
    rem_r    <= rem_nxt;
    sburst_r <= sburst_nxt;
    arr_r    <= arr_nxt;
    sord_r   <= sord_nxt;
    bslot_r  <= bslot_nxt;
    bprio_r  <= bprio_nxt;
    bord_r   <= bord_nxt;
    bid_r    <= bid_nxt;
    bburst_r <= bburst_nxt;
    btime_r  <= btime_nxt;
  end

  assign ctrl_o  = bctrl_r;
  assign slot_o  = bslot_r;
  assign prio_o  = bprio_r;
  assign order_o = bord_r;
  assign id_o    = bid_r;
  assign burst_o = bburst_r;
  assign time_o  = btime_r;

endmodule

FILE: src/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: control sequencer and the chain of slot cells.
`timescale 1ns / 1ps

// Preemptive priority scheduler over MAX_TASKS task slots. Each slot lives in
// one cell of a chain, and every operation is a sweep that moves one cell per
// clock along that chain. An item is taken when start is high and busy is
// low; busy stays high until the item's result has been produced. The result
// appears on the out_ ports for exactly one cycle with out_valid high, and
// must be captured then: the block has no way to hold it back. An arrival
// costs one sweep. A tick costs one selection sweep plus, when a task runs,
// one execution sweep over the same chain, and a task that finishes adds the
// ST_CALC state that reports its times. The next item may be started in the
// cycle in which the previous result is shown.
module preemptive_priority_scheduler_unit
  import ppsu_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [BURST_W-1:0] in_burst_len,
  input  logic [INPR_W-1:0]  in_prio,
  output logic               out_valid,
  output logic               out_accepted,
  output logic               out_run_valid,
  output logic [ID_W-1:0]    out_run_id,
  output logic               out_finished,
  output logic [OUT_W-1:0]   out_wait_time,
  output logic [OUT_W-1:0]   out_turnaround
);

  localparam int SLOT_BITS = $clog2(MAX_TASKS);
  // width wide enough for both time values and the burst
  localparam int WB = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [WB-1:0] OUT_MAX = WB'({OUT_W{1'b1}});

  // Chain bus: index 0 is driven here, index MAX_TASKS is the tail
  ppsu_ctrl_t           ch_ctrl  [MAX_TASKS+1];
  logic [SLOT_BITS-1:0] ch_slot  [MAX_TASKS+1];
  logic [PRIO_BITS-1:0] ch_prio  [MAX_TASKS+1];
  logic [ORDER_W-1:0]   ch_order [MAX_TASKS+1];
  logic [ID_W-1:0]      ch_id    [MAX_TASKS+1];
  logic [BURST_W-1:0]   ch_burst [MAX_TASKS+1];
  logic [TIME_BITS-1:0] ch_time  [MAX_TASKS+1];

  // Control state
  ppsu_state_t          state_r,     state_nxt;
  logic                 launch_r,    launch_nxt;
  ppsu_op_t             lop_r,       lop_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [SLOT_BITS-1:0] run_slot_r,  run_slot_nxt;
  logic [PRIO_BITS-1:0] run_prio_r,  run_prio_nxt;
  logic [TIME_BITS-1:0] now_r,       now_nxt;
  logic [ORDER_W-1:0]   entry_cnt_r, entry_cnt_nxt;

  // Request capture and finish bookkeeping
  logic [ID_W-1:0]      req_id_r,    req_id_nxt;
  logic [BURST_W-1:0]   req_burst_r, req_burst_nxt;
  logic [PRIO_BITS-1:0] req_prio_r,  req_prio_nxt;
  logic [WB-1:0]        ta_r,        ta_nxt;
  logic [BURST_W-1:0]   fin_burst_r, fin_burst_nxt;
  logic [ID_W-1:0]      fin_id_r,    fin_id_nxt;

  // Result register
  logic               ov_r,  ov_nxt;
  logic               oacc_r, oacc_nxt;
  logic               orun_r, orun_nxt;
  logic [ID_W-1:0]    oid_r, oid_nxt;
  logic               ofin_r, ofin_nxt;
  logic [OUT_W-1:0]   owt_r, owt_nxt;
  logic [OUT_W-1:0]   ota_r, ota_nxt;

  logic                 tail_valid;
  logic                 pick;
  logic [TIME_BITS-1:0] now_adv;
  logic [TIME_BITS-1:0] ta_raw;
  logic [WB-1:0]        burst_wide;
  logic [WB-1:0]        wt_raw;

  // ---------------------------------------------------------------------------
  // Chain head: launch one sweep with the captured request or the running slot
  // ---------------------------------------------------------------------------
  assign ch_ctrl[0].valid = launch_r;
  assign ch_ctrl[0].op    = lop_r;
  assign ch_ctrl[0].hit   = 1'b0;
  assign ch_slot[0]       = run_slot_r;
  assign ch_prio[0]       = req_prio_r;
  assign ch_order[0]      = entry_cnt_r;
  assign ch_id[0]         = req_id_r;
  assign ch_burst[0]      = req_burst_r;
  assign ch_time[0]       = now_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      ppsu_cell #(
        .SLOT_BITS (SLOT_BITS),
        .PRIO_BITS (PRIO_BITS),
        .TIME_BITS (TIME_BITS),
        .CELL_IDX  (gi)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_valid_i (run_valid_r),
        .run_slot_i  (run_slot_r),
        .ctrl_i      (ch_ctrl[gi]),
        .slot_i      (ch_slot[gi]),
        .prio_i      (ch_prio[gi]),
        .order_i     (ch_order[gi]),
        .id_i        (ch_id[gi]),
        .burst_i     (ch_burst[gi]),
        .time_i      (ch_time[gi]),
        .ctrl_o      (ch_ctrl[gi+1]),
        .slot_o      (ch_slot[gi+1]),
        .prio_o      (ch_prio[gi+1]),
        .order_o     (ch_order[gi+1]),
        .id_o        (ch_id[gi+1]),
        .burst_o     (ch_burst[gi+1]),
        .time_o      (ch_time[gi+1])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Datapath helpers for the sequencer
  // ---------------------------------------------------------------------------
  assign tail_valid = ch_ctrl[MAX_TASKS].valid;

  // Preempt only on a strictly lower priority number
  assign pick = ch_ctrl[MAX_TASKS].hit &&
                (!run_valid_r || (ch_prio[MAX_TASKS] < run_prio_r));

  // Saturating time advance; also the completion time of a finishing task
  assign now_adv = (now_r == TIME_MAX) ? now_r : now_r + TIME_BITS'(1);

  assign ta_raw = (now_adv >= ch_time[MAX_TASKS]) ? now_adv - ch_time[MAX_TASKS]
                                                   : '0;

  assign burst_wide = WB'(fin_burst_r);
  assign wt_raw     = (ta_r >= burst_wide) ? ta_r - burst_wide : '0;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    lop_nxt       = lop_r;
    run_valid_nxt = run_valid_r;
    run_slot_nxt  = run_slot_r;
    run_prio_nxt  = run_prio_r;
    now_nxt       = now_r;
    entry_cnt_nxt = entry_cnt_r;
    req_id_nxt    = req_id_r;
    req_burst_nxt = req_burst_r;
    req_prio_nxt  = req_prio_r;
    ta_nxt        = ta_r;
    fin_burst_nxt = fin_burst_r;
    fin_id_nxt    = fin_id_r;
    ov_nxt        = 1'b0;
    oacc_nxt      = oacc_r;
    orun_nxt      = orun_r;
    oid_nxt       = oid_r;
    ofin_nxt      = ofin_r;
    owt_nxt       = owt_r;
    ota_nxt       = ota_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // capture the item and launch its first sweep
          req_id_nxt    = in_task_id;
          req_burst_nxt = in_burst_len;
          req_prio_nxt  = PRIO_BITS'(in_prio);
          launch_nxt    = 1'b1;
          if (in_req_type) begin
            lop_nxt   = OP_SCAN;
            state_nxt = ST_SCAN;
          end else begin
            lop_nxt   = OP_ARRIVE;
            state_nxt = ST_ARRIVE;
          end
        end
      end

      ST_ARRIVE: begin
        if (tail_valid) begin
          // a hit at the tail means some free slot took the task
          ov_nxt   = 1'b1;
          oacc_nxt = ch_ctrl[MAX_TASKS].hit;
          orun_nxt = 1'b0;
          oid_nxt  = '0;
          ofin_nxt = 1'b0;
          owt_nxt  = '0;
          ota_nxt  = '0;
          if (ch_ctrl[MAX_TASKS].hit) begin
            entry_cnt_nxt = entry_cnt_r + ORDER_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (tail_valid) begin
          if (pick) begin
            run_valid_nxt = 1'b1;
            run_slot_nxt  = ch_slot[MAX_TASKS];
            run_prio_nxt  = ch_prio[MAX_TASKS];
          end
          if (pick || run_valid_r) begin
            // run one unit of the chosen task
            launch_nxt = 1'b1;
            lop_nxt    = OP_EXEC;
            state_nxt  = ST_EXEC;
          end else begin
            // idle tick: nothing to run, time still advances
            ov_nxt    = 1'b1;
            oacc_nxt  = 1'b0;
            orun_nxt  = 1'b0;
            oid_nxt   = '0;
            ofin_nxt  = 1'b0;
            owt_nxt   = '0;
            ota_nxt   = '0;
            now_nxt   = now_adv;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EXEC: begin
        if (tail_valid) begin
          if (ch_ctrl[MAX_TASKS].hit) begin
            // task completed: its slot is already freed in the cell
            run_valid_nxt = 1'b0;
            ta_nxt        = WB'(ta_raw);
            fin_burst_nxt = ch_burst[MAX_TASKS];
            fin_id_nxt    = ch_id[MAX_TASKS];
            state_nxt     = ST_CALC;
          end else begin
            ov_nxt    = 1'b1;
            oacc_nxt  = 1'b0;
            orun_nxt  = 1'b1;
            oid_nxt   = ch_id[MAX_TASKS];
            ofin_nxt  = 1'b0;
            owt_nxt   = '0;
            ota_nxt   = '0;
            now_nxt   = now_adv;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_CALC: begin
        // report waiting and turnaround, both saturated to the port width
        ov_nxt    = 1'b1;
        oacc_nxt  = 1'b0;
        orun_nxt  = 1'b1;
        oid_nxt   = fin_id_r;
        ofin_nxt  = 1'b1;
        owt_nxt   = (wt_raw > OUT_MAX) ? {OUT_W{1'b1}} : wt_raw[OUT_W-1:0];
        ota_nxt   = (ta_r > OUT_MAX) ? {OUT_W{1'b1}} : ta_r[OUT_W-1:0];
        now_nxt   = now_adv;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      lop_r       <= OP_ARRIVE;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      run_prio_r  <= '0;
      now_r       <= '0;
      entry_cnt_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      lop_r       <= lop_nxt;
      run_valid_r <= run_valid_nxt;
      run_slot_r  <= run_slot_nxt;
      run_prio_r  <= run_prio_nxt;
      now_r       <= now_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_id_r    <= req_id_nxt;
    req_burst_r <= req_burst_nxt;
    req_prio_r  <= req_prio_nxt;
    ta_r        <= ta_nxt;
    fin_burst_r <= fin_burst_nxt;
    fin_id_r    <= fin_id_nxt;
    oacc_r      <= oacc_nxt;
    orun_r      <= orun_nxt;
    oid_r       <= oid_nxt;
    ofin_r      <= ofin_nxt;
    owt_r       <= owt_nxt;
    ota_r       <= ota_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_accepted   = oacc_r;
  assign out_run_valid  = orun_r;
  assign out_run_id     = oid_r;
  assign out_finished   = ofin_r;
  assign out_wait_time  = owt_r;
  assign out_turnaround = ota_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tail_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid |-> (state_r != ST_IDLE))
    else $error("sweep reached the chain tail while the sequencer was idle");

  a_exec_tail_op: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_valid && (state_r == ST_EXEC)) |-> (ch_ctrl[MAX_TASKS].op == OP_EXEC))
    else $error("execution state saw a sweep of another kind at the tail");

  a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |=> !launch_r)
    else $error("two sweeps launched in consecutive cycles");

  a_finish_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_run_valid && !out_accepted))
    else $error("finished result without a running task");

  a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_valid && (state_r == ST_ARRIVE) && ch_ctrl[MAX_TASKS].hit)
      |=> (entry_cnt_r == ORDER_W'($past(entry_cnt_r) + ORDER_W'(1))))
    else $error("accepted arrival did not advance the entry counter");

endmodule
